// File: rtl/rem_pkg.sv
package rem_pkg;

	// Field widths of the item and result beats
	localparam int ROW_IDX_W = 3;
	localparam int COL_IDX_W = 2;
	localparam int ELEM_W    = 16;
	localparam int COL_POS_W = 2;
	localparam int COUNT_W   = 5;

	// Saturation point of the match counter
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

endpackage

// File: rtl/rem_in_if.sv
interface rem_in_if
	import rem_pkg::*;
();
	logic                        valid;
	logic                        ready;
	opcode_t                     opcode;
	logic [ROW_IDX_W-1:0]        row_index;
	logic [COL_IDX_W-1:0]        col_index;
	logic signed [ELEM_W-1:0]    element_value;

	modport source (output valid, opcode, row_index, col_index, element_value, input ready);
	modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

// File: rtl/rem_out_if.sv
interface rem_out_if
	import rem_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [COL_POS_W-1:0]  column_position;
	logic [COUNT_W-1:0]    match_count;
	logic                  last_of_run;

	modport source (output valid, column_position, match_count, last_of_run, input ready);
	modport sink (input valid, column_position, match_count, last_of_run, output ready);
endinterface

// File: rtl/row_element_match_counter.sv
// Channel   Dir  Beat contents
// item      in   opcode, row_index, col_index, element_value
// result    out  column_position, match_count, last_of_run
//
// A load beat is written in the accepting cycle. A query beat, without stalls, runs the
// accepting cycle, then per key column a key read, a sweep of every matrix cell through
// the single read port of the matrix memory, a drain of the read, and a result that is
// shown until taken.
// Reset clears the control state only; the matrix memory holds garbage until loaded.
// item.ready is high only while idle; a stalled result holds the block in its result state.
module row_element_match_counter
	import rem_pkg::*;
#(
	parameter int ROWS        = 8,
	parameter int COLS        = 4,
	parameter int VALUE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rem_in_if.sink      item,
	rem_out_if.source   result
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

	localparam logic [AW-1:0] COLS_A   = AW'(COLS);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_SCAN,
		S_DRAIN,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [RW-1:0]          key_row_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          scan_row_q;
	logic [CW-1:0]          scan_col_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   key_s1;
	logic                   scan_s1;
	logic [RW-1:0]          row_s1;

	logic [VALUE_WIDTH-1:0] mem_q [CELLS];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	logic                   accept;
	logic                   row_ok;
	logic                   col_ok;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic signed [31:0]     elem_ext;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   match;
	logic [COUNT_W-1:0]     count_next;
	logic                   scan_last;

	// Decode the incoming beat
	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign row_ok     = 32'(item.row_index) < 32'(ROWS);
	assign col_ok     = 32'(item.col_index) < 32'(COLS);
	assign elem_ext   = 32'(item.element_value);

	assign wr_en   = accept && (item.opcode == OP_LOAD) && row_ok && col_ok;
	assign wr_addr = AW'(AW'(item.row_index) * COLS_A + AW'(item.col_index));
	assign wr_data = elem_ext[VALUE_WIDTH-1:0];

	// Pick the read address: key element, then the sweep
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_KEY: begin
				rd_en   = 1'b1;
				rd_addr = AW'(AW'(key_row_q) * COLS_A + AW'(col_q));
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = AW'(AW'(scan_row_q) * COLS_A + AW'(scan_col_q));
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// Matrix memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Compare the returning element against the key, skip the key row
	assign match      = scan_s1 && (row_s1 != key_row_q) && (rd_data_q == key_q);
	assign count_next = (match && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;
	assign scan_last  = (scan_row_q == ROW_LAST) && (scan_col_q == COL_LAST);

	// Sequencer: key read, sweep, drain, hold result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_row_q  <= '0;
			col_q      <= '0;
			scan_row_q <= '0;
			scan_col_q <= '0;
			key_q      <= '0;
			count_q    <= '0;
			key_s1     <= 1'b0;
			scan_s1    <= 1'b0;
			row_s1     <= '0;
		end else begin
			key_s1  <= (state_q == S_KEY);
			scan_s1 <= (state_q == S_SCAN);
			row_s1  <= scan_row_q;
			if (key_s1) begin
				key_q <= rd_data_q;
			end
			// restart the tally on each key read
			count_q <= (state_q == S_KEY) ? '0 : count_next;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.opcode == OP_QUERY) && row_ok) begin
						key_row_q <= RW'(item.row_index);
						col_q     <= '0;
						state_q   <= S_KEY;
					end
				end
				S_KEY: begin
					scan_row_q <= '0;
					scan_col_q <= '0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					// advance row-major: step the column within a row, then move to the next row
					if (scan_col_q == COL_LAST) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + 1'b1;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
					end
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						if (col_q == COL_LAST) begin
							state_q <= S_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_KEY;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Drive the result beat
	assign result.valid           = (state_q == S_OUT);
	assign result.column_position = COL_POS_W'(col_q);
	assign result.match_count     = count_q;
	assign result.last_of_run     = (col_q == COL_LAST);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench
	import rem_pkg::*;
();

	localparam int ROWS        = 8;
	localparam int COLS        = 4;
	localparam int VALUE_WIDTH = 16;

	localparam int CLK_PERIOD   = 20;
	localparam int RANDOM_ITEMS = 54;
	// Longest quiet stretch of a correct run is one column sweep plus a result stall
	localparam int IDLE_LIMIT   = 4000;
	// One query sweep plus stalls on every result beat
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		opcode_t                    op;
		logic [ROW_IDX_W-1:0]       row;
		logic [COL_IDX_W-1:0]       col;
		logic signed [ELEM_W-1:0]   value;
	} item_beat_t;

	typedef struct {
		logic [COL_POS_W-1:0] column;
		logic [COUNT_W-1:0]   count;
		logic                 last;
	} column_tally_t;

	logic clk;
	logic arst_n;

	rem_in_if  item_ch ();
	rem_out_if res_ch ();

	row_element_match_counter #(
		.ROWS        (ROWS),
		.COLS        (COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	item_beat_t    pending_beats [$];
	column_tally_t expected_tallies [$];

	// Local copy of the matrix, at the block's element width
	logic [VALUE_WIDTH-1:0] cell_store [ROWS][COLS];

	int   error_count    = 0;
	int   loads_seen     = 0;
	int   queries_seen   = 0;
	int   tallies_seen   = 0;
	int   idle_cycles    = 0;
	int   burst_left     = 1;
	int   gap_left       = 0;
	int   pattern_left   = 0;
	logic [31:0] ready_pattern = '1;
	logic item_taken     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic push_load(input int row, input int col, input logic signed [ELEM_W-1:0] v);
		item_beat_t b;
		b.op    = OP_LOAD;
		b.row   = ROW_IDX_W'(row);
		b.col   = COL_IDX_W'(col);
		b.value = v;
		pending_beats.push_back(b);
	endtask

	// Column and value fields carry junk on a query; the block must ignore them
	task automatic push_query(input int row);
		item_beat_t b;
		b.op    = OP_QUERY;
		b.row   = ROW_IDX_W'(row);
		b.col   = COL_IDX_W'($urandom);
		b.value = ELEM_W'($urandom);
		pending_beats.push_back(b);
	endtask

	// Favor a small pool of values so that matches are common
	function automatic logic signed [ELEM_W-1:0] pick_value();
		logic signed [ELEM_W-1:0] pool [6];
		pool = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sh1, 16'sh0001, 16'sh5a5a};
		if ($urandom_range(0, 1) == 0)
			return pool[$urandom_range(0, 5)];
		return ELEM_W'($urandom);
	endfunction

	// Store one element: sign-extend, then keep the low element bits
	task automatic apply_load(input item_beat_t b);
		if (b.row < ROWS && b.col < COLS)
			cell_store[b.row][b.col] = VALUE_WIDTH'(32'(b.value));
	endtask

	// Count matches of each key-row element among all other rows
	task automatic tally_key_row(input logic [ROW_IDX_W-1:0] key_row);
		column_tally_t t;
		logic [COUNT_W-1:0] hits;
		if (key_row >= ROWS)
			return;
		for (int c = 0; c < COLS; c++) begin
			hits = '0;
			for (int r = 0; r < ROWS; r++) begin
				if (r == key_row)
					continue;
				for (int k = 0; k < COLS; k++) begin
					if (cell_store[r][k] == cell_store[key_row][c] && hits != COUNT_MAX)
						hits++;
				end
			end
			t.column = COL_POS_W'(c);
			t.count  = hits;
			t.last   = (c == COLS - 1);
			expected_tallies.push_back(t);
		end
	endtask

	// Feed item beats in bursts with random gaps between them
	always @(negedge clk) begin : drive_items
		item_beat_t b;
		if (arst_n) begin
			if (item_taken) begin
				void'(pending_beats.pop_front());
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end
			item_ch.valid <= (gap_left == 0) && (pending_beats.size() != 0);
			if (pending_beats.size() != 0) begin
				b = pending_beats[0];
				item_ch.opcode        <= b.op;
				item_ch.row_index     <= b.row;
				item_ch.col_index     <= b.col;
				item_ch.element_value <= b.value;
			end
		end
	end

	// Stall the result side on a rotating 32-bit pattern, reloaded after each full rotation
	always @(negedge clk) begin
		if (pattern_left == 0) begin
			ready_pattern = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
			pattern_left  = 32;
		end
		res_ch.ready  <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
		pattern_left--;
	end

	// Predict on accepted item beats, check accepted result beats
	always @(posedge clk) begin : watch_beats
		item_beat_t    b;
		column_tally_t want;
		logic          any_beat;
		if (arst_n) begin
			any_beat = 1'b0;
			item_taken <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				any_beat = 1'b1;
				b.op    = item_ch.opcode;
				b.row   = item_ch.row_index;
				b.col   = item_ch.col_index;
				b.value = item_ch.element_value;
				if (b.op == OP_LOAD) begin
					loads_seen++;
					apply_load(b);
				end else begin
					queries_seen++;
					tally_key_row(b.row);
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				any_beat = 1'b1;
				tallies_seen++;
				if (expected_tallies.size() == 0) begin
					flag_error($sformatf("unexpected result beat col %0d count %0d last %0d",
						res_ch.column_position, res_ch.match_count, res_ch.last_of_run));
				end else begin
					want = expected_tallies.pop_front();
					if (res_ch.column_position !== want.column)
						flag_error($sformatf("column_position got %0d expected %0d",
							res_ch.column_position, want.column));
					if (res_ch.match_count !== want.count)
						flag_error($sformatf("match_count got %0d expected %0d (col %0d)",
							res_ch.match_count, want.count, want.column));
					if (res_ch.last_of_run !== want.last)
						flag_error($sformatf("last_of_run got %0d expected %0d (col %0d)",
							res_ch.last_of_run, want.last, want.column));
				end
			end
			// Abort when the block goes quiet for too long
			idle_cycles = any_beat ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] timeout: no beat for %0d cycles", $realtime, IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		// Hold every block input at a known value
		arst_n                = 1'b0;
		item_ch.valid         = 1'b0;
		item_ch.opcode        = OP_LOAD;
		item_ch.row_index     = '0;
		item_ch.col_index     = '0;
		item_ch.element_value = '0;
		res_ch.ready          = 1'b0;

		// Fill the whole matrix before any query: every element equal, most negative
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				push_load(r, c, 16'sh8000);
		// Full-count case on the first and the last row
		push_query(0);
		push_query(ROWS - 1);
		// Key row of extremes that nothing else matches
		push_load(2, 0, 16'sh7fff);
		push_load(2, 1, -16'sh1);
		push_load(2, 2, 16'sh0000);
		push_load(2, 3, 16'sh0001);
		push_query(2);
		// One match for the all-ones element, then the opposite view
		push_load(6, 3, -16'sh1);
		push_query(2);
		push_query(6);
		push_load(7, 3, 16'sh7fff);
		push_load(5, 1, 16'sh0000);
		push_query(7);
		push_query(5);

		// Random mix: mostly loads, about a quarter queries
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 3) == 0)
				push_query($urandom_range(0, ROWS - 1));
			else
				push_load($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
					pick_value());
		end

		repeat (9) @(posedge clk);
		#(CLK_PERIOD / 4) arst_n = 1'b1;

		// Drain: all beats sent, all results back, then let the block settle
		while (pending_beats.size() != 0 || expected_tallies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d key-row queries; checked %0d column tallies.",
			loads_seen, queries_seen, tallies_seen);
		$display("Mismatches: %0d", error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
